/* hw/rtl/emds_pkg.sv */
// Shared constants and types for the extruder motor drive sequencer.
package emds_pkg;

    // Stepper accumulator rollover: one full half-step pair per rollover.
    localparam int ACC_WRAP_COUNT  = 6375 / 2;
    localparam int ACC_BITS        = $clog2(ACC_WRAP_COUNT);
    // Signed sum of accumulator and speed needs room for sign and overflow.
    localparam int ACC_SUM_BITS    = ACC_BITS + 2;

    // External step counter width and the width of its compare.
    localparam int TICK_COUNT_BITS = 24;
    localparam int PERIOD_BITS     = 24;
    localparam int CMP_BITS        = (TICK_COUNT_BITS >= PERIOD_BITS) ?
                                     TICK_COUNT_BITS + 1 : PERIOD_BITS + 1;

    localparam int SPEED_BITS      = 9;
    localparam int DUTY_BITS       = 8;
    localparam int PHASE_BITS      = 3;

    // Half-step patterns, one bit per phase.
    localparam logic [7:0] HB1_EN_PAT  = 8'hdd;
    localparam logic [7:0] HB1_DIR_PAT = 8'hc3;
    localparam logic [7:0] HB2_EN_PAT  = 8'h77;
    localparam logic [7:0] HB2_DIR_PAT = 8'hf0;

    localparam logic [PHASE_BITS-1:0] PHASE_RESET = PHASE_BITS'(1);
    localparam logic [PHASE_BITS-1:0] PHASE_STEP  = PHASE_BITS'(2);

    // Drive mode codes; the unused code drives like DC.
    localparam logic [1:0] MODE_DC       = 2'd0;
    localparam logic [1:0] MODE_STEPPER  = 2'd1;
    localparam logic [1:0] MODE_EXTERNAL = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DRIVE_MODE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MOTOR_SPEED  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SWAP_BRIDGES = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXT_PERIOD   = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXT_DIR      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXT_RUN      = 3'd5;
    localparam int CFG_DATA_BITS = 24;

    // Speed written as -256 saturates to -255.
    localparam logic [SPEED_BITS-1:0] SPEED_MOST_NEG = 9'h100;
    localparam logic [SPEED_BITS-1:0] SPEED_SAT_NEG  = 9'h101;

    // Result item, highest bit first when packed into m_tdata.
    typedef struct packed {
        logic                 pad;
        logic                 ext_disable;
        logic                 ext_dir;
        logic                 ext_step;
        logic [DUTY_BITS-1:0] dc_duty;
        logic                 bridge2_dir;
        logic                 bridge2_enable;
        logic                 bridge1_dir;
        logic                 bridge1_enable;
    } result_t;

endpackage

/* hw/rtl/extruder_motor_drive_sequencer_core.sv */
// Extruder motor drive sequencer: DC, internal half-step and external step/dir drive.
//
// Usage:
//   Each request on the s_ channel carries one flag, advance. With advance set
//   one timer tick is applied to the state of the active drive mode; with it
//   clear the block only reports the current drive lines. Every request yields
//   exactly one result on the m_ channel holding all eight drive lines.
//   The cfg_ channel writes the six mode registers by index; it is always ready
//   and is meant to be used only while no request is in flight.
// Throughput:
//   An accepted request's result is written to the output register, or to the
//   skid register while it stalls. One request is taken every cycle while
//   s_tready is high; accumulator and step counter add/compare are combinational.
// Stall behavior:
//   A skid register behind the output register takes one more result while
//   m_tready is low; s_tready drops only once the skid register is full.
// Reset:
//   aresetn (synchronous, active low) clears both output slots, all mode
//   registers, the accumulator, the gate toggle and the step counter, and
//   sets the half-step phase to one.
module extruder_motor_drive_sequencer_core (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] advance, [7:1] zero

    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] bridge1_enable, [1] bridge1_dir, [2] bridge2_enable, [3] bridge2_dir,
    // [11:4] dc_duty, [12] ext_step, [13] ext_dir, [14] ext_disable, [15] zero
    output logic [15:0] m_tdata,

    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [emds_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [emds_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    // Mode registers
    logic [1:0]                          drive_mode_reg;
    logic signed [emds_pkg::SPEED_BITS-1:0] motor_speed_reg;
    logic                                swap_bridges_reg;
    logic [emds_pkg::PERIOD_BITS-1:0]    ext_period_reg;
    logic                                ext_direction_reg;
    logic                                ext_run_reg;

    // Drive state
    logic [emds_pkg::ACC_BITS-1:0]        acc_reg, acc_next;
    logic [emds_pkg::PHASE_BITS-1:0]      phase_reg, phase_next;
    logic                                 gate_reg, gate_next;
    logic [emds_pkg::TICK_COUNT_BITS-1:0] count_reg, count_next;

    // Output slots
    logic                out_valid_reg, skid_valid_reg;
    emds_pkg::result_t   out_data_reg, skid_data_reg;
    emds_pkg::result_t   result;

    logic advance;
    logic accept;
    logic step_fire;

    logic signed [emds_pkg::ACC_SUM_BITS-1:0] acc_sum;
    logic [emds_pkg::CMP_BITS-1:0]            count_inc;
    logic [emds_pkg::CMP_BITS-1:0]            count_left;
    logic [7:0]                               phase_mask;
    logic                                     step_en;
    logic [emds_pkg::DUTY_BITS-1:0]           speed_mag;
    logic                                     dc_en, dc_dir;

    assign advance   = s_tdata[0];
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_mode_reg    <= emds_pkg::MODE_DC;
            motor_speed_reg   <= '0;
            swap_bridges_reg  <= 1'b0;
            ext_period_reg    <= '0;
            ext_direction_reg <= 1'b0;
            ext_run_reg       <= 1'b0;
        end else if (cfg_valid) begin
            case (cfg_index)
                emds_pkg::REG_DRIVE_MODE:   drive_mode_reg <= cfg_data[1:0];
                emds_pkg::REG_MOTOR_SPEED: begin
                    if (cfg_data[emds_pkg::SPEED_BITS-1:0] == emds_pkg::SPEED_MOST_NEG) begin
                        motor_speed_reg <= emds_pkg::SPEED_SAT_NEG;
                    end else begin
                        motor_speed_reg <= cfg_data[emds_pkg::SPEED_BITS-1:0];
                    end
                end
                emds_pkg::REG_SWAP_BRIDGES: swap_bridges_reg  <= cfg_data[0];
                emds_pkg::REG_EXT_PERIOD:   ext_period_reg    <= cfg_data;
                emds_pkg::REG_EXT_DIR:      ext_direction_reg <= cfg_data[0];
                emds_pkg::REG_EXT_RUN:      ext_run_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Next state and the result for the request at the input.
    always_comb begin
        acc_next   = acc_reg;
        phase_next = phase_reg;
        gate_next  = gate_reg;
        count_next = count_reg;
        step_fire  = 1'b0;

        // Stepper: add speed, roll the phase on over/underflow.
        acc_sum = emds_pkg::ACC_SUM_BITS'(signed'({1'b0, acc_reg}))
                + emds_pkg::ACC_SUM_BITS'(motor_speed_reg);

        // External: count ticks, fire once the period is reached.
        count_inc  = emds_pkg::CMP_BITS'(count_reg) + emds_pkg::CMP_BITS'(1);
        count_left = count_inc - emds_pkg::CMP_BITS'(ext_period_reg);

        if (accept && advance) begin
            case (drive_mode_reg)
                emds_pkg::MODE_STEPPER: begin
                    gate_next = !gate_reg;
                    if (acc_sum >= emds_pkg::ACC_SUM_BITS'(emds_pkg::ACC_WRAP_COUNT)) begin
                        acc_next   = emds_pkg::ACC_BITS'(acc_sum
                                   - emds_pkg::ACC_SUM_BITS'(emds_pkg::ACC_WRAP_COUNT));
                        phase_next = phase_reg + emds_pkg::PHASE_STEP;
                    end else if (acc_sum < 0) begin
                        acc_next   = emds_pkg::ACC_BITS'(acc_sum
                                   + emds_pkg::ACC_SUM_BITS'(emds_pkg::ACC_WRAP_COUNT));
                        phase_next = phase_reg - emds_pkg::PHASE_STEP;
                    end else begin
                        acc_next   = emds_pkg::ACC_BITS'(acc_sum);
                    end
                end
                emds_pkg::MODE_EXTERNAL: begin
                    if (ext_period_reg != '0 && ext_run_reg) begin
                        if (count_inc >= emds_pkg::CMP_BITS'(ext_period_reg)) begin
                            step_fire  = 1'b1;
                            count_next = emds_pkg::TICK_COUNT_BITS'(count_left);
                        end else begin
                            count_next = emds_pkg::TICK_COUNT_BITS'(count_inc);
                        end
                    end
                end
                default: ;
            endcase
        end

        // Stepper lines follow the phase and gate after this tick.
        phase_mask = 8'(1) << phase_next;
        step_en    = (motor_speed_reg != '0) && gate_next;

        // DC lines
        speed_mag = motor_speed_reg[emds_pkg::SPEED_BITS-1] ?
                    emds_pkg::DUTY_BITS'(-motor_speed_reg) :
                    emds_pkg::DUTY_BITS'(motor_speed_reg);
        dc_en  = (motor_speed_reg != '0);
        dc_dir = !motor_speed_reg[emds_pkg::SPEED_BITS-1];

        result = '0;
        result.ext_disable = 1'b1;
        case (drive_mode_reg)
            emds_pkg::MODE_STEPPER: begin
                result.bridge1_dir    = |(emds_pkg::HB1_DIR_PAT & phase_mask);
                result.bridge1_enable = step_en && |(emds_pkg::HB1_EN_PAT & phase_mask);
                result.bridge2_dir    = |(emds_pkg::HB2_DIR_PAT & phase_mask);
                result.bridge2_enable = step_en && |(emds_pkg::HB2_EN_PAT & phase_mask);
            end
            emds_pkg::MODE_EXTERNAL: begin
                result.ext_step    = step_fire;
                result.ext_dir     = ext_direction_reg;
                result.ext_disable = (ext_period_reg == '0);
            end
            default: begin
                // DC, and the unused code behaves the same
                result.dc_duty = speed_mag;
                if (swap_bridges_reg) begin
                    result.bridge2_enable = dc_en;
                    result.bridge2_dir    = dc_dir;
                end else begin
                    result.bridge1_enable = dc_en;
                    result.bridge1_dir    = dc_dir;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            phase_reg <= emds_pkg::PHASE_RESET;
            gate_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            acc_reg   <= acc_next;
            phase_reg <= phase_next;
            gate_reg  <= gate_next;
            count_reg <= count_next;
        end
    end

    // Output register with skid slot behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= accept;
            end
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (accept) begin
                out_data_reg <= result;
            end
        end else if (accept) begin
            skid_data_reg <= result;
        end
    end

endmodule

/* verif/extruder_motor_drive_sequencer_core_chk.sv */
`timescale 1ns / 1ps
// Checker for the extruder motor drive sequencer: predicts and compares every drive result.
module extruder_motor_drive_sequencer_core_chk (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [7:0]                          s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [15:0]                         m_tdata,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [emds_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [emds_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output int                                  fail_count,
    output int                                  pending
);

    // Mode registers as the block should hold them.
    logic [1:0]                             mode_r;
    logic signed [emds_pkg::SPEED_BITS-1:0] speed_r;
    logic                                   swap_r;
    logic [emds_pkg::PERIOD_BITS-1:0]       period_r;
    logic                                   ext_dir_r;
    logic                                   ext_run_r;

    // Drive state.
    int                                     rate_acc;
    logic [emds_pkg::PHASE_BITS-1:0]        half_phase;
    logic                                   gate_q;
    logic [emds_pkg::TICK_COUNT_BITS-1:0]   tick_count;

    emds_pkg::result_t drive_lines_due[$];
    int                mismatches = 0;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: drive result mismatch on %s: got %0d, expected %0d",
                 $time, what, got, want);
        mismatches++;
    endtask

    // Apply one request to the drive state and return the lines it reports.
    function automatic emds_pkg::result_t predict_drive_lines(input logic adv);
        emds_pkg::result_t                  r;
        int                                 sum;
        int                                 mag;
        logic [emds_pkg::TICK_COUNT_BITS:0] next_count;
        logic                               en;
        r = '0;
        r.ext_disable = 1'b1;
        case (mode_r)
            emds_pkg::MODE_STEPPER: begin
                if (adv) begin
                    sum = rate_acc + int'(speed_r);
                    if (sum >= emds_pkg::ACC_WRAP_COUNT) begin
                        sum -= emds_pkg::ACC_WRAP_COUNT;
                        half_phase += emds_pkg::PHASE_STEP;
                    end else if (sum < 0) begin
                        sum += emds_pkg::ACC_WRAP_COUNT;
                        half_phase -= emds_pkg::PHASE_STEP;
                    end
                    rate_acc = sum;
                    gate_q   = ~gate_q;
                end
                en = (speed_r != 0) && gate_q;
                r.bridge1_dir    = emds_pkg::HB1_DIR_PAT[half_phase];
                r.bridge1_enable = en && emds_pkg::HB1_EN_PAT[half_phase];
                r.bridge2_dir    = emds_pkg::HB2_DIR_PAT[half_phase];
                r.bridge2_enable = en && emds_pkg::HB2_EN_PAT[half_phase];
            end
            emds_pkg::MODE_EXTERNAL: begin
                if (adv && period_r != 0 && ext_run_r) begin
                    next_count = {1'b0, tick_count} + 1'b1;
                    // Compare before the wrap; an overrun fires and keeps the rest.
                    if (next_count >= {1'b0, period_r}) begin
                        next_count = next_count - {1'b0, period_r};
                        r.ext_step = 1'b1;
                    end
                    tick_count = next_count[emds_pkg::TICK_COUNT_BITS-1:0];
                end
                r.ext_dir     = ext_dir_r;
                r.ext_disable = (period_r == 0);
            end
            default: begin
                mag = (speed_r < 0) ? -int'(speed_r) : int'(speed_r);
                if (mag > 255)
                    mag = 255;
                r.dc_duty = mag[emds_pkg::DUTY_BITS-1:0];
                en = (speed_r != 0);
                if (swap_r) begin
                    r.bridge2_enable = en;
                    r.bridge2_dir    = (speed_r >= 0);
                end else begin
                    r.bridge1_enable = en;
                    r.bridge1_dir    = (speed_r >= 0);
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        emds_pkg::result_t got;
        emds_pkg::result_t want;
        if (!aresetn) begin
            mode_r     = emds_pkg::MODE_DC;
            speed_r    = '0;
            swap_r     = 1'b0;
            period_r   = '0;
            ext_dir_r  = 1'b0;
            ext_run_r  = 1'b0;
            rate_acc   = 0;
            half_phase = emds_pkg::PHASE_RESET;
            gate_q     = 1'b0;
            tick_count = '0;
            drive_lines_due.delete();
        end else begin
            // Results first: one taken now was requested on an earlier edge.
            if (m_tvalid && m_tready) begin
                got = emds_pkg::result_t'(m_tdata);
                if (drive_lines_due.size() == 0) begin
                    report_mismatch("result with nothing due", 1, 0);
                end else begin
                    want = drive_lines_due.pop_front();
                    if (got.bridge1_enable !== want.bridge1_enable)
                        report_mismatch("bridge1_enable", int'(got.bridge1_enable),
                                        int'(want.bridge1_enable));
                    if (got.bridge1_dir !== want.bridge1_dir)
                        report_mismatch("bridge1_dir", int'(got.bridge1_dir),
                                        int'(want.bridge1_dir));
                    if (got.bridge2_enable !== want.bridge2_enable)
                        report_mismatch("bridge2_enable", int'(got.bridge2_enable),
                                        int'(want.bridge2_enable));
                    if (got.bridge2_dir !== want.bridge2_dir)
                        report_mismatch("bridge2_dir", int'(got.bridge2_dir),
                                        int'(want.bridge2_dir));
                    if (got.dc_duty !== want.dc_duty)
                        report_mismatch("dc_duty", int'(got.dc_duty), int'(want.dc_duty));
                    if (got.ext_step !== want.ext_step)
                        report_mismatch("ext_step", int'(got.ext_step), int'(want.ext_step));
                    if (got.ext_dir !== want.ext_dir)
                        report_mismatch("ext_dir", int'(got.ext_dir), int'(want.ext_dir));
                    if (got.ext_disable !== want.ext_disable)
                        report_mismatch("ext_disable", int'(got.ext_disable),
                                        int'(want.ext_disable));
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    emds_pkg::REG_DRIVE_MODE:   mode_r = cfg_data[1:0];
                    emds_pkg::REG_MOTOR_SPEED: begin
                        if (cfg_data[emds_pkg::SPEED_BITS-1:0] == emds_pkg::SPEED_MOST_NEG)
                            speed_r = emds_pkg::SPEED_SAT_NEG;
                        else
                            speed_r = cfg_data[emds_pkg::SPEED_BITS-1:0];
                    end
                    emds_pkg::REG_SWAP_BRIDGES: swap_r    = cfg_data[0];
                    emds_pkg::REG_EXT_PERIOD:   period_r  = cfg_data[emds_pkg::PERIOD_BITS-1:0];
                    emds_pkg::REG_EXT_DIR:      ext_dir_r = cfg_data[0];
                    emds_pkg::REG_EXT_RUN:      ext_run_r = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                drive_lines_due.push_back(predict_drive_lines(s_tdata[0]));
        end
        pending <= drive_lines_due.size();
    end

endmodule

/* verif/extruder_motor_drive_sequencer_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the extruder motor drive sequencer: stimulus, flow control and verdict.
module extruder_motor_drive_sequencer_core_tb;

    localparam int PHASES          = 20;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int HOLD_PHASE      = 6;
    localparam int HOLD_CYCLES     = 400;
    localparam int DRAIN_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 200000;
    localparam logic [emds_pkg::CFG_DATA_BITS-1:0] PERIOD_MAX = '1;

    logic                                aclk      = 1'b0;
    logic                                aresetn   = 1'b0;
    logic                                s_tvalid  = 1'b0;
    logic                                s_tready;
    logic [7:0]                          s_tdata   = '0;   // [0] advance, [7:1] zero
    logic                                m_tvalid;
    logic                                m_tready  = 1'b0;
    // [0] b1 enable, [1] b1 dir, [2] b2 enable, [3] b2 dir, [11:4] duty,
    // [12] ext_step, [13] ext_dir, [14] ext_disable, [15] zero
    logic [15:0]                         m_tdata;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [emds_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [emds_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

    int   fail_count;
    int   pending;
    int   cycles        = 0;
    int   send_idle_pct = 0;   // touched only by the stimulus process
    int   rx_stall_pct  = 0;   // set by nonblocking write, read by the receiver
    logic hold_req      = 1'b0;

    extruder_motor_drive_sequencer_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    extruder_motor_drive_sequencer_core_chk chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Abort a run that hangs: a lost result or a stuck handshake ends up here.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("extruder_motor_drive_sequencer_core_tb NOT OK");
            $finish;
        end
    end

    // Result side: stall at the phase's rate, or hold off for a long stretch on
    // request so the skid slot fills and the block pushes back on its input.
    initial begin : receiver
        int   hold_left;
        logic hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req && !hold_taken) begin
                hold_left  = HOLD_CYCLES - 1;
                hold_taken = 1'b1;
                m_tready   <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Offer one request, after a random gap at the phase's idle rate; return
    // right after the edge that took it. Keep valid high when no gap follows.
    task automatic send_request(input logic adv);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, adv};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid and wait until every result due has been taken.
    task automatic quiesce();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Write one register; leave cfg_valid high so a batch runs back to back.
    task automatic set_reg(input logic [emds_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [emds_pkg::CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    function automatic logic [emds_pkg::CFG_DATA_BITS-1:0] speed_word(input int s);
        speed_word = '0;
        speed_word[emds_pkg::SPEED_BITS-1:0] = s[emds_pkg::SPEED_BITS-1:0];
    endfunction

    initial begin : stimulus
        int pick;
        int speed;
        logic [emds_pkg::CFG_DATA_BITS-1:0] period;
        logic [1:0] mode;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: DC mode at speed zero, report-only and a tick.
        send_request(1'b0);
        send_request(1'b1);

        // DC extremes: full forward on bridge one, full reverse on bridge two.
        quiesce();
        set_reg(emds_pkg::REG_MOTOR_SPEED, speed_word(255));
        cfg_valid <= 1'b0;
        send_request(1'b1);
        quiesce();
        set_reg(emds_pkg::REG_MOTOR_SPEED, speed_word(-255));
        set_reg(emds_pkg::REG_SWAP_BRIDGES, emds_pkg::CFG_DATA_BITS'(1));
        cfg_valid <= 1'b0;
        send_request(1'b0);

        // Most negative speed word saturates.
        quiesce();
        set_reg(emds_pkg::REG_MOTOR_SPEED, speed_word(-256));
        cfg_valid <= 1'b0;
        send_request(1'b1);

        // Unused mode code behaves as DC.
        quiesce();
        set_reg(emds_pkg::REG_DRIVE_MODE, emds_pkg::CFG_DATA_BITS'(emds_pkg::MODE_UNUSED));
        cfg_valid <= 1'b0;
        send_request(1'b1);

        // Stepper: enables low before the first tick, underflow steps back,
        // then full speed forward, then speed zero gates the bridges off.
        quiesce();
        set_reg(emds_pkg::REG_DRIVE_MODE, emds_pkg::CFG_DATA_BITS'(emds_pkg::MODE_STEPPER));
        set_reg(emds_pkg::REG_MOTOR_SPEED, speed_word(-1));
        cfg_valid <= 1'b0;
        send_request(1'b0);
        send_request(1'b1);
        quiesce();
        set_reg(emds_pkg::REG_MOTOR_SPEED, speed_word(255));
        cfg_valid <= 1'b0;
        send_request(1'b1);
        send_request(1'b1);
        quiesce();
        set_reg(emds_pkg::REG_MOTOR_SPEED, speed_word(0));
        cfg_valid <= 1'b0;
        send_request(1'b1);

        // External: zero period disables, period one steps every tick,
        // run low holds the count.
        quiesce();
        set_reg(emds_pkg::REG_DRIVE_MODE, emds_pkg::CFG_DATA_BITS'(emds_pkg::MODE_EXTERNAL));
        set_reg(emds_pkg::REG_EXT_PERIOD, emds_pkg::CFG_DATA_BITS'(0));
        cfg_valid <= 1'b0;
        send_request(1'b1);
        quiesce();
        set_reg(emds_pkg::REG_EXT_PERIOD, emds_pkg::CFG_DATA_BITS'(1));
        set_reg(emds_pkg::REG_EXT_DIR, emds_pkg::CFG_DATA_BITS'(1));
        set_reg(emds_pkg::REG_EXT_RUN, emds_pkg::CFG_DATA_BITS'(1));
        cfg_valid <= 1'b0;
        send_request(1'b1);
        send_request(1'b1);
        quiesce();
        set_reg(emds_pkg::REG_EXT_RUN, emds_pkg::CFG_DATA_BITS'(0));
        cfg_valid <= 1'b0;
        send_request(1'b1);

        // Overrun: count up under a long period, then shorten it below the count.
        quiesce();
        set_reg(emds_pkg::REG_EXT_RUN, emds_pkg::CFG_DATA_BITS'(1));
        set_reg(emds_pkg::REG_EXT_PERIOD, emds_pkg::CFG_DATA_BITS'(5));
        cfg_valid <= 1'b0;
        send_request(1'b1);
        send_request(1'b1);
        send_request(1'b1);
        quiesce();
        set_reg(emds_pkg::REG_EXT_PERIOD, emds_pkg::CFG_DATA_BITS'(1));
        cfg_valid <= 1'b0;
        send_request(1'b1);
        send_request(1'b1);
        quiesce();
        set_reg(emds_pkg::REG_EXT_PERIOD, PERIOD_MAX);
        set_reg(emds_pkg::REG_EXT_DIR, emds_pkg::CFG_DATA_BITS'(0));
        cfg_valid <= 1'b0;
        send_request(1'b1);

        // Random phases: rewrite a random subset of registers while idle, then
        // stream requests, mostly ticks, under the phase's flow-control mix.
        for (int p = 0; p < PHASES; p++) begin
            quiesce();
            if (p == 0 || $urandom_range(1)) begin
                pick = $urandom_range(9);
                mode = (pick < 3) ? emds_pkg::MODE_DC :
                       (pick < 6) ? emds_pkg::MODE_STEPPER :
                       (pick < 9) ? emds_pkg::MODE_EXTERNAL : emds_pkg::MODE_UNUSED;
                set_reg(emds_pkg::REG_DRIVE_MODE, emds_pkg::CFG_DATA_BITS'(mode));
            end
            if (p == 0 || $urandom_range(1)) begin
                case ($urandom_range(7))
                    0:       speed = 255;
                    1:       speed = -255;
                    2:       speed = -256;
                    3:       speed = 0;
                    default: speed = int'($urandom_range(511)) - 256;
                endcase
                set_reg(emds_pkg::REG_MOTOR_SPEED, speed_word(speed));
            end
            if (p == 0 || $urandom_range(1))
                set_reg(emds_pkg::REG_SWAP_BRIDGES,
                        emds_pkg::CFG_DATA_BITS'($urandom_range(1)));
            if (p == 0 || $urandom_range(1)) begin
                pick = $urandom_range(19);
                if (pick < 2)
                    period = '0;
                else if (pick == 2)
                    period = PERIOD_MAX;
                else if (pick < 5)
                    period = emds_pkg::CFG_DATA_BITS'($urandom_range(PERIOD_MAX));
                else if (pick < 8)
                    period = emds_pkg::CFG_DATA_BITS'($urandom_range(9, 40));
                else
                    period = emds_pkg::CFG_DATA_BITS'($urandom_range(1, 8));
                set_reg(emds_pkg::REG_EXT_PERIOD, period);
            end
            if (p == 0 || $urandom_range(1))
                set_reg(emds_pkg::REG_EXT_DIR, emds_pkg::CFG_DATA_BITS'($urandom_range(1)));
            if (p == 0 || $urandom_range(1))
                set_reg(emds_pkg::REG_EXT_RUN,
                        emds_pkg::CFG_DATA_BITS'($urandom_range(4) != 0));
            cfg_valid <= 1'b0;

            case (p % 4)
                0: begin send_idle_pct = 0;  rx_stall_pct <= 0;  end
                1: begin send_idle_pct = 52; rx_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  rx_stall_pct <= 52; end
                default: begin send_idle_pct = 37; rx_stall_pct <= 37; end
            endcase
            // Hold the result side off while requests keep coming.
            if (p == HOLD_PHASE)
                hold_req <= 1'b1;

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_request($urandom_range(9) < 8);
        end

        quiesce();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("extruder_motor_drive_sequencer_core_tb OK");
        else
            $display("extruder_motor_drive_sequencer_core_tb NOT OK");
        $finish;
    end

endmodule
